// File: sv/assert_macros.svh
// Assertion helpers for the RTL (included by mfg_dp); the clock is clk and the reset is rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define MFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MFG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mfg_pkg.sv
// ----------------------------------------------------------------------------
// mfg_pkg
// Shared constants, controller states, datapath operations and the
// command/status bundles of the max-flow solver.
// ----------------------------------------------------------------------------
package mfg_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_ARCS  = 32768;
  localparam int POP_DEPTH = MAX_NODES + 1;

  localparam int NODE_W = 10;
  localparam int ARC_W  = 15;
  localparam int PTR_W  = 16;
  localparam int CAP_W  = 61;
  localparam int FLOW_W = 63;
  localparam int LBL_W  = 11;
  localparam int IN_W   = 88;
  localparam int OUT_W  = 64;
  localparam int USER_W = 2;

  localparam logic [PTR_W-1:0]  PTR_NIL  = {1'b1, {(PTR_W-1){1'b0}}};
  localparam logic [CAP_W-1:0]  CAP_INF  = {1'b1, {(CAP_W-1){1'b0}}};
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};
  localparam logic [LBL_W-1:0]  NODE_MIN = LBL_W'(2);
  localparam logic [LBL_W-1:0]  NODE_MAX = LBL_W'(MAX_NODES);
  localparam logic [PTR_W-1:0]  ARC_LIMIT = PTR_W'(MAX_ARCS - 2);
  localparam logic [NODE_W-1:0] SINK_NODE = NODE_W'(1);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD_FWD, ST_LOAD_REV, ST_INIT, ST_TOP, ST_FETCH_CUR,
    ST_SCAN, ST_ARC, ST_TEST, ST_AUG_FLOW, ST_AUG_PRED, ST_AUG_CUR, ST_AUG_FWD,
    ST_AUG_REV, ST_RL_FIRST, ST_RL_FETCH, ST_RL_SCAN, ST_RL_ARC, ST_RL_TEST,
    ST_RL_POP, ST_RL_DEC, ST_RL_SET, ST_RL_INC, ST_RL_PRED, ST_RL_DLAT, ST_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_LOAD_FWD, OP_LOAD_REV, OP_INIT, OP_TOP, OP_FETCH_CUR,
    OP_SCAN, OP_ARC, OP_TEST, OP_AUG_FLOW, OP_AUG_PRED, OP_AUG_CUR, OP_AUG_FWD,
    OP_AUG_REV, OP_RL_FIRST, OP_RL_FETCH, OP_RL_SCAN, OP_RL_ARC, OP_RL_TEST,
    OP_RL_POP, OP_RL_DEC, OP_RL_SET, OP_RL_INC, OP_RL_PRED, OP_RL_DLAT, OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic j_nil;
    logic test_ok;
    logic v_sink;
    logic u_zero;
    logic d0_done;
    logic du_le_n;
    logic pop_one;
    logic init_done;
    logic clr_done;
    logic out_busy;
  } status_t;

endpackage

// File: sv/mfg_ram.sv
// ----------------------------------------------------------------------------
// mfg_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module mfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/mfg_ctrl.sv
// ----------------------------------------------------------------------------
// mfg_ctrl
// Sequencer for edge loading, the augmenting-path search, augmentation,
// relabel with gap exit, result hand-off and the list-head clearing sweep.
// ----------------------------------------------------------------------------
module mfg_ctrl
  import mfg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (status.clr_done) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid) state_next = ST_LOAD_FWD;
      ST_LOAD_FWD: begin
        if (!status.full) state_next = ST_LOAD_REV;
        else if (status.last) state_next = ST_INIT;
        else state_next = ST_IDLE;
      end
      ST_LOAD_REV:  state_next = status.last ? ST_INIT : ST_IDLE;
      ST_INIT:      if (status.init_done) state_next = ST_TOP;
      ST_TOP:       state_next = status.d0_done ? ST_FINISH : ST_FETCH_CUR;
      ST_FETCH_CUR: state_next = ST_SCAN;
      ST_SCAN:      state_next = status.j_nil ? ST_RL_FIRST : ST_ARC;
      ST_ARC:       state_next = ST_TEST;
      ST_TEST: begin
        if (!status.test_ok) state_next = ST_SCAN;
        else if (status.v_sink) state_next = ST_AUG_FLOW;
        else state_next = ST_TOP;
      end
      ST_AUG_FLOW:  state_next = ST_AUG_PRED;
      ST_AUG_PRED:  state_next = ST_AUG_CUR;
      ST_AUG_CUR:   state_next = ST_AUG_FWD;
      ST_AUG_FWD:   state_next = ST_AUG_REV;
      ST_AUG_REV:   state_next = status.u_zero ? ST_TOP : ST_AUG_PRED;
      ST_RL_FIRST:  state_next = ST_RL_FETCH;
      ST_RL_FETCH:  state_next = ST_RL_SCAN;
      ST_RL_SCAN:   state_next = status.j_nil ? ST_RL_POP : ST_RL_ARC;
      ST_RL_ARC:    state_next = ST_RL_TEST;
      ST_RL_TEST:   state_next = ST_RL_SCAN;
      ST_RL_POP:    state_next = status.du_le_n ? ST_RL_DEC : ST_RL_SET;
      // an emptied label means no augmenting path remains
      ST_RL_DEC:    state_next = status.pop_one ? ST_FINISH : ST_RL_SET;
      ST_RL_SET:    state_next = ST_RL_INC;
      ST_RL_INC:    state_next = ST_RL_PRED;
      ST_RL_PRED:   state_next = ST_RL_DLAT;
      ST_RL_DLAT:   state_next = ST_TOP;
      ST_FINISH:    if (!status.out_busy) state_next = ST_CLEAR;
      default:      state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = OP_IDLE;
    unique case (state)
      ST_CLEAR:     cmd.op = OP_CLEAR;
      ST_IDLE: begin
        cmd.op       = OP_IDLE;
        cmd.in_ready = 1'b1;
      end
      ST_LOAD_FWD:  cmd.op = OP_LOAD_FWD;
      ST_LOAD_REV:  cmd.op = OP_LOAD_REV;
      ST_INIT:      cmd.op = OP_INIT;
      ST_TOP:       cmd.op = OP_TOP;
      ST_FETCH_CUR: cmd.op = OP_FETCH_CUR;
      ST_SCAN:      cmd.op = OP_SCAN;
      ST_ARC:       cmd.op = OP_ARC;
      ST_TEST:      cmd.op = OP_TEST;
      ST_AUG_FLOW:  cmd.op = OP_AUG_FLOW;
      ST_AUG_PRED:  cmd.op = OP_AUG_PRED;
      ST_AUG_CUR:   cmd.op = OP_AUG_CUR;
      ST_AUG_FWD:   cmd.op = OP_AUG_FWD;
      ST_AUG_REV:   cmd.op = OP_AUG_REV;
      ST_RL_FIRST:  cmd.op = OP_RL_FIRST;
      ST_RL_FETCH:  cmd.op = OP_RL_FETCH;
      ST_RL_SCAN:   cmd.op = OP_RL_SCAN;
      ST_RL_ARC:    cmd.op = OP_RL_ARC;
      ST_RL_TEST:   cmd.op = OP_RL_TEST;
      ST_RL_POP:    cmd.op = OP_RL_POP;
      ST_RL_DEC:    cmd.op = OP_RL_DEC;
      ST_RL_SET:    cmd.op = OP_RL_SET;
      ST_RL_INC:    cmd.op = OP_RL_INC;
      ST_RL_PRED:   cmd.op = OP_RL_PRED;
      ST_RL_DLAT:   cmd.op = OP_RL_DLAT;
      ST_FINISH:    cmd.op = OP_FINISH;
      default:      cmd.op = OP_IDLE;
    endcase
  end

endmodule

// File: sv/mfg_dp.sv
// ----------------------------------------------------------------------------
// mfg_dp
// Solver datapath: arc and node memories, search registers, flow
// accumulator, node_count register and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfg_dp
  import mfg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_data,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  out_data,
  output logic [USER_W-1:0] out_user,
  input  logic              cfg_we,
  input  logic [LBL_W-1:0]  cfg_wdata
);

  // request fields
  logic [NODE_W-1:0] in_from_w, in_to_w;
  logic [CAP_W-1:0]  in_cap_w;
  assign in_from_w = in_data[NODE_W-1:0];
  assign in_to_w   = in_data[2*NODE_W-1:NODE_W];
  assign in_cap_w  = in_data[2*NODE_W+CAP_W-1:2*NODE_W];

  // registers
  logic [LBL_W-1:0]  node_count;
  logic [NODE_W-1:0] in_from, in_to;
  logic [CAP_W-1:0]  in_cap;
  logic              in_lastr;
  logic [PTR_W-1:0]  ac;
  logic              dropped;
  logic [LBL_W-1:0]  cnt;
  logic [NODE_W-1:0] u, v;
  logic [PTR_W-1:0]  j, link;
  logic [CAP_W-1:0]  r, aug;
  logic [LBL_W-1:0]  du, d0, mindis;
  logic [FLOW_W-1:0] flow, out_flow;
  logic              sat, out_sat, out_ovf;

  // memory ports
  logic              arc_we, res_we;
  logic [ARC_W-1:0]  arc_waddr, res_waddr, arc_raddr, res_raddr;
  logic [NODE_W-1:0] tgt_wdata, tgt_rdata;
  logic [PTR_W-1:0]  lnk_wdata, lnk_rdata;
  logic [CAP_W-1:0]  res_wdata, res_rdata;
  logic              first_we, cur_we, pred_we, dist_we, pop_we;
  logic [NODE_W-1:0] first_waddr, first_raddr, cur_waddr, cur_raddr;
  logic [NODE_W-1:0] pred_waddr, pred_raddr, dist_waddr, dist_raddr;
  logic [PTR_W-1:0]  first_wdata, first_rdata, cur_wdata, cur_rdata;
  logic [NODE_W-1:0] pred_wdata, pred_rdata;
  logic [LBL_W-1:0]  dist_wdata, dist_rdata;
  logic [LBL_W-1:0]  pop_waddr, pop_raddr, pop_wdata, pop_rdata;

  // derived values
  logic [LBL_W-1:0]  n, new_lbl, cnt_m1;
  logic [PTR_W-1:0]  ac_odd, rev_link;
  logic [ARC_W-1:0]  j_idx, j_pair;
  logic              v_in, test_ok, rl_better, full;
  logic [FLOW_W:0]   flow_sum;
  logic [CAP_W-1:0]  aug_min;

  always_comb begin
    if (node_count < NODE_MIN) n = NODE_MIN;
    else if (node_count > NODE_MAX) n = NODE_MAX;
    else n = node_count;
  end

  assign new_lbl   = mindis + LBL_W'(1);
  assign cnt_m1    = cnt - LBL_W'(1);
  assign ac_odd    = {ac[PTR_W-1:1], 1'b1};
  assign rev_link  = (in_from == in_to) ? ac : first_rdata;
  assign j_idx     = j[ARC_W-1:0];
  assign j_pair    = {j[ARC_W-1:1], ~j[0]};
  assign v_in      = {1'b0, v} < n;
  assign test_ok   = v_in && (r != '0) && ({1'b0, du} == ({1'b0, dist_rdata} + 12'd1));
  assign rl_better = v_in && (r != '0) && (dist_rdata < mindis);
  assign full      = ac > ARC_LIMIT;
  assign flow_sum  = {1'b0, flow} + {3'b000, aug};
  assign aug_min   = (r < aug) ? r : aug;

  always_comb begin
    status.full      = full;
    status.last      = in_lastr;
    status.j_nil     = j[PTR_W-1];
    status.test_ok   = test_ok;
    status.v_sink    = (v == SINK_NODE);
    status.u_zero    = (u == '0);
    status.d0_done   = (d0 >= n);
    status.du_le_n   = (du <= n);
    status.pop_one   = (pop_rdata == LBL_W'(1));
    status.init_done = (cnt == n);
    status.clr_done  = (cnt[NODE_W-1:0] == {NODE_W{1'b1}});
    status.out_busy  = out_valid;
  end

  // memory port steering
  always_comb begin
    arc_we      = 1'b0;
    arc_waddr   = ac[ARC_W-1:0];
    tgt_wdata   = in_to;
    lnk_wdata   = first_rdata;
    arc_raddr   = j_idx;
    res_we      = 1'b0;
    res_waddr   = ac[ARC_W-1:0];
    res_wdata   = in_cap;
    res_raddr   = j_idx;
    first_we    = 1'b0;
    first_waddr = in_from;
    first_wdata = ac;
    first_raddr = u;
    cur_we      = 1'b0;
    cur_waddr   = u;
    cur_wdata   = j;
    cur_raddr   = u;
    pred_we     = 1'b0;
    pred_waddr  = v;
    pred_wdata  = u;
    pred_raddr  = u;
    dist_we     = 1'b0;
    dist_waddr  = u;
    dist_wdata  = new_lbl;
    dist_raddr  = tgt_rdata;
    pop_we      = 1'b0;
    pop_waddr   = du;
    pop_wdata   = pop_rdata - LBL_W'(1);
    pop_raddr   = du;
    unique case (cmd.op)
      OP_CLEAR: begin
        first_we    = 1'b1;
        first_waddr = cnt[NODE_W-1:0];
        first_wdata = PTR_NIL;
      end
      OP_IDLE: first_raddr = in_from_w;
      OP_LOAD_FWD: begin
        arc_we      = !full;
        res_we      = !full;
        first_we    = !full;
        first_raddr = in_to;
      end
      OP_LOAD_REV: begin
        arc_we      = !full;
        arc_waddr   = ac_odd[ARC_W-1:0];
        tgt_wdata   = in_from;
        lnk_wdata   = rev_link;
        res_we      = !full;
        res_waddr   = ac_odd[ARC_W-1:0];
        res_wdata   = '0;
        first_we    = !full;
        first_waddr = in_to;
        first_wdata = ac_odd;
      end
      OP_INIT: begin
        first_raddr = cnt[NODE_W-1:0];
        cur_we      = (cnt != '0);
        cur_waddr   = cnt_m1[NODE_W-1:0];
        cur_wdata   = first_rdata;
        dist_we     = (cnt < n);
        dist_waddr  = cnt[NODE_W-1:0];
        dist_wdata  = '0;
        pop_we      = 1'b1;
        pop_waddr   = cnt;
        pop_wdata   = (cnt == '0) ? n : '0;
        pred_we     = (cnt == '0);
        pred_waddr  = '0;
        pred_wdata  = '0;
      end
      OP_SCAN: begin
        cur_we    = j[PTR_W-1];
        cur_wdata = PTR_NIL;
      end
      OP_TEST: begin
        cur_we  = test_ok;
        pred_we = test_ok;
      end
      OP_AUG_PRED: cur_raddr = pred_rdata;
      OP_AUG_CUR:  res_raddr = cur_rdata[ARC_W-1:0];
      OP_AUG_FWD: begin
        res_we    = 1'b1;
        res_waddr = j_idx;
        res_wdata = res_rdata - aug;
        res_raddr = j_pair;
      end
      OP_AUG_REV: begin
        res_we    = 1'b1;
        res_waddr = j_pair;
        res_wdata = res_rdata + aug;
      end
      OP_RL_TEST: cur_we = rl_better;
      OP_RL_DEC:  pop_we = 1'b1;
      OP_RL_SET: begin
        dist_we   = 1'b1;
        pop_raddr = new_lbl;
      end
      OP_RL_INC: begin
        pop_we    = (new_lbl <= n);
        pop_waddr = new_lbl;
        pop_wdata = pop_rdata + LBL_W'(1);
      end
      OP_RL_PRED: dist_raddr = pred_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_MIN;
      ac         <= '0;
      dropped    <= 1'b0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == OP_INIT || cmd.op == OP_CLEAR) begin
        cnt <= cnt + LBL_W'(1);
      end else begin
        cnt <= '0;
      end
      unique case (cmd.op)
        OP_LOAD_FWD: if (full) dropped <= 1'b1;
        OP_LOAD_REV: if (!full) ac <= ac + PTR_W'(2);
        OP_FINISH: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            ac        <= '0;
            dropped   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and search registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_IDLE: begin
        if (in_valid && cmd.in_ready) begin
          in_from  <= in_from_w;
          in_to    <= in_to_w;
          in_cap   <= (in_cap_w > CAP_INF) ? CAP_INF : in_cap_w;
          in_lastr <= in_last;
        end
      end
      OP_INIT: begin
        u    <= '0;
        du   <= '0;
        d0   <= '0;
        flow <= '0;
        sat  <= 1'b0;
        aug  <= CAP_INF;
      end
      OP_FETCH_CUR: j <= cur_rdata;
      OP_ARC, OP_RL_ARC: begin
        v    <= tgt_rdata;
        r    <= res_rdata;
        link <= lnk_rdata;
      end
      OP_TEST: begin
        if (test_ok) begin
          aug <= aug_min;
          u   <= v;
          du  <= dist_rdata;
        end else begin
          j <= link;
        end
      end
      OP_AUG_FLOW: begin
        if (flow_sum[FLOW_W]) begin
          flow <= FLOW_MAX;
          sat  <= 1'b1;
        end else begin
          flow <= flow_sum[FLOW_W-1:0];
        end
      end
      OP_AUG_PRED: u <= pred_rdata;
      OP_AUG_CUR:  j <= cur_rdata;
      OP_AUG_REV: begin
        if (u == '0) begin
          aug <= CAP_INF;
          du  <= d0;
        end
      end
      OP_RL_FIRST: mindis <= n;
      OP_RL_FETCH: j <= first_rdata;
      OP_RL_TEST: begin
        if (rl_better) mindis <= dist_rdata;
        j <= link;
      end
      OP_RL_SET:  if (u == '0) d0 <= new_lbl;
      OP_RL_PRED: u <= pred_rdata;
      OP_RL_DLAT: du <= dist_rdata;
      OP_FINISH: begin
        if (!out_valid) begin
          out_flow <= flow;
          out_sat  <= sat;
          out_ovf  <= dropped;
        end
      end
      default: ;
    endcase
  end

  assign out_data = {1'b0, out_flow};
  assign out_user = {out_ovf, out_sat};

  mfg_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ARCS)) u_tgt (
    .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(tgt_wdata),
    .raddr(arc_raddr), .rdata(tgt_rdata)
  );
  mfg_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ARCS)) u_lnk (
    .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(lnk_wdata),
    .raddr(arc_raddr), .rdata(lnk_rdata)
  );
  mfg_ram #(.WIDTH(CAP_W), .DEPTH(MAX_ARCS)) u_res (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr), .rdata(res_rdata)
  );
  mfg_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_first (
    .clk(clk), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
    .raddr(first_raddr), .rdata(first_rdata)
  );
  mfg_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_cur (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_raddr), .rdata(cur_rdata)
  );
  mfg_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_pred (
    .clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
    .raddr(pred_raddr), .rdata(pred_rdata)
  );
  mfg_ram #(.WIDTH(LBL_W), .DEPTH(MAX_NODES)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );
  mfg_ram #(.WIDTH(LBL_W), .DEPTH(POP_DEPTH)) u_pop (
    .clk(clk), .we(pop_we), .waddr(pop_waddr), .wdata(pop_wdata),
    .raddr(pop_raddr), .rdata(pop_rdata)
  );

  `MFG_ASSERT(a_ac_pair, (cmd.op == OP_LOAD_REV && !full) |=> (ac == $past(ac) + 16'd2), "arc count did not advance by one pair")
  `MFG_ASSERT(a_result_clears, $rose(out_valid) |-> (ac == '0 && !dropped), "graph not cleared with result")
  `MFG_ASSERT(a_aug_rearm, (cmd.op == OP_AUG_REV && u == '0) |=> (aug == CAP_INF && du == d0), "augment limit not rearmed at source")
  `MFG_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "result valid after reset")

endmodule

// File: sv/max_flow_isap_gap_top.sv
// ----------------------------------------------------------------------------
// max_flow_isap_gap_top
// Max-flow solver (shortest augmenting path with gap exit) over edges loaded
// one request at a time; the last edge starts the solve from node 0 to node 1.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                data
//  s_axis    in   s_axis_tvalid/tready     tdata: from_node, to_node, capacity
//                                          tlast: last_edge
//  m_axis    out  m_axis_tvalid/tready     tdata: max_flow
//                                          tuser: flow_saturated, edge_overflow
//  cfg       in   cfg_we                   cfg_wdata: node_count
//
// An edge takes a list-head read, then a forward and, unless the arcs are full, a
// reverse arc step. Solve: init sweep, then scan, fetch and test per scanned arc
// and pred, cur, forward and reverse steps per path arc, bound by single memory
// ports. After reset and after each result a sweep clears all 1024 list heads;
// no request is taken during it. A pending result waits in its own register
// while the next graph loads; a new result waits only if that one is unclaimed.
module max_flow_isap_gap_top
  import mfg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // from_node, to_node, capacity, zero fill
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // max_flow, zero fill
  output logic [USER_W-1:0] m_axis_tuser,   // flow_saturated, edge_overflow
  input  logic              cfg_we,
  input  logic [LBL_W-1:0]  cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  assign s_axis_tready = cmd.in_ready;

  mfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  mfg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule
